// ===== rtl/gn3d_pkg.sv =====
// Package for the gradient noise block: widths, codes, permutation table, helpers.
package gn3d_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 24;
   localparam int OUT_W     = 17;
   localparam int VAL_W     = 22;
   localparam int CSR_W     = 2;

   localparam logic [CSR_W-1:0] DIM_1D = 2'd1;
   localparam logic [CSR_W-1:0] DIM_2D = 2'd2;
   localparam logic [CSR_W-1:0] DIM_3D = 2'd3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [7:0] hash_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   // signed fixed-point product, rounded on magnitudes, ties away from zero
   function automatic val_type qmul(input val_type a, input val_type b);
      logic             neg;
      logic [VAL_W-1:0] ua;
      logic [VAL_W-1:0] ub;
      logic [2*VAL_W-1:0] p;
      logic [2*VAL_W-1:0] r;
      neg = a[VAL_W-1] ^ b[VAL_W-1];
      ua  = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      ub  = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
      p   = {{VAL_W{1'b0}}, ua} * {{VAL_W{1'b0}}, ub};
      r   = (p + (2*VAL_W)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return neg ? -val_type'(r[VAL_W-1:0]) : val_type'(r[VAL_W-1:0]);
   endfunction

   function automatic val_type grad(input hash_type hash, input val_type x,
                                    input val_type y, input val_type z);
      logic [3:0] h;
      val_type    u;
      val_type    v;
      h = hash[3:0];
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic val_type lerp(input val_type a, input val_type b, input val_type t);
      return a + qmul(t, b - a);
   endfunction

endpackage

// ===== rtl/gradient_noise_3d.sv =====
// Top level of the gradient noise block: hashing, fade and blend pipeline.
//
//   channel   ports                          handshake
//   request   req_coord_x/y/z                start & !busy
//   response  rsp_noise_value                rsp_valid, one cycle, no backpressure
//   config    csr_data                       csr_valid & csr_ready
//
// One point enters per cycle; rsp_valid follows each accepted point through the valid
// shift register. The fade polynomial (three products deep) and the three blend levels
// set the depth, one product per stage. Reset clears the valid bits and sets dimensions
// to 3D. busy stays low since the receiver cannot stall; csr_ready is always high.
module gradient_noise_3d (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [gn3d_pkg::COORD_W-1:0]         req_coord_x,
   input  logic [gn3d_pkg::COORD_W-1:0]         req_coord_y,
   input  logic [gn3d_pkg::COORD_W-1:0]         req_coord_z,
   output logic                                 rsp_valid,
   output logic [gn3d_pkg::OUT_W-1:0]           rsp_noise_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gn3d_pkg::CSR_W-1:0]           csr_data
);
   import gn3d_pkg::*;

   localparam int NS = 9;
   localparam val_type ONE = val_type'(1 << FRAC_BITS);

   logic [CSR_W-1:0] dim_ff;
   logic [NS-1:0]    vld_ff;

   // stage 1: lattice indices, first hash
   logic [7:0]   s1_a_ff, s1_b_ff, s1_y_ff, s1_z_ff;
   val_type      s1_x_ff, s1_yf_ff, s1_zf_ff;
   logic [CSR_W-1:0] s1_dim_ff;
   // stage 2: second hash
   hash_type     s2_aa_ff, s2_ab_ff, s2_ba_ff, s2_bb_ff;
   logic [7:0]   s2_z_ff, s2_a_ff, s2_b_ff;
   // stage 3: corner hashes
   hash_type     s3_h_ff [8];
   // shared fraction and fade pipes
   val_type      x_ff [2:NS-1];
   val_type      y_ff [2:NS-1];
   val_type      z_ff [2:NS-1];
   logic [CSR_W-1:0] dim_p_ff [2:NS-1];
   val_type      f2_in [3], f2_ff [3];   // t*(6t-15)+10 inner, combinational and registered
   val_type      f3_ff [3][2];           // poly, cube
   val_type      fade_ff [3];
   // stage 4: gradients; stage 5: gradients held for the fade
   val_type      g4_ff [8];
   val_type      g5_ff [8];
   // stage 6..8: blends
   val_type      l5_ff [4];
   val_type      l6_ff [2];
   val_type      n7_ff;

   logic [1:0]   dsel;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_3D;
         vld_ff <= '0;
      end else begin
         if (csr_valid) begin
            dim_ff <= csr_data;
         end
         vld_ff <= {vld_ff[NS-2:0], start};
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      s1_a_ff   <= PERM_ROM[req_coord_x[FRAC_BITS +: 8]];
      s1_b_ff   <= PERM_ROM[8'(req_coord_x[FRAC_BITS +: 8] + 8'd1)];
      s1_y_ff   <= req_coord_y[FRAC_BITS +: 8];
      s1_z_ff   <= req_coord_z[FRAC_BITS +: 8];
      s1_x_ff   <= val_type'(req_coord_x[FRAC_BITS-1:0]);
      s1_yf_ff  <= val_type'(req_coord_y[FRAC_BITS-1:0]);
      s1_zf_ff  <= val_type'(req_coord_z[FRAC_BITS-1:0]);
      s1_dim_ff <= dim_ff;
   end

   // stage 2
   always_ff @(posedge clock) begin
      s2_aa_ff <= PERM_ROM[8'(s1_a_ff + s1_y_ff)];
      s2_ab_ff <= PERM_ROM[8'(s1_a_ff + s1_y_ff + 8'd1)];
      s2_ba_ff <= PERM_ROM[8'(s1_b_ff + s1_y_ff)];
      s2_bb_ff <= PERM_ROM[8'(s1_b_ff + s1_y_ff + 8'd1)];
      s2_a_ff  <= s1_a_ff;
      s2_b_ff  <= s1_b_ff;
      s2_z_ff  <= s1_z_ff;
      x_ff[2]     <= s1_x_ff;
      y_ff[2]     <= s1_yf_ff;
      z_ff[2]     <= s1_zf_ff;
      dim_p_ff[2] <= s1_dim_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 3; i < NS; i++) begin
         x_ff[i]     <= x_ff[i-1];
         y_ff[i]     <= y_ff[i-1];
         z_ff[i]     <= z_ff[i-1];
         dim_p_ff[i] <= dim_p_ff[i-1];
      end
   end

   assign dsel = dim_p_ff[2];

   // stage 3: corner hashes per mode
   always_ff @(posedge clock) begin
      if (dsel == DIM_1D) begin
         for (int i = 0; i < 8; i++) begin
            s3_h_ff[i] <= i[0] ? s2_b_ff : s2_a_ff;
         end
      end else if (dsel == DIM_2D) begin
         s3_h_ff[0] <= s2_aa_ff;
         s3_h_ff[1] <= s2_ba_ff;
         s3_h_ff[2] <= s2_ab_ff;
         s3_h_ff[3] <= s2_bb_ff;
         s3_h_ff[4] <= s2_aa_ff;
         s3_h_ff[5] <= s2_ba_ff;
         s3_h_ff[6] <= s2_ab_ff;
         s3_h_ff[7] <= s2_bb_ff;
      end else begin
         s3_h_ff[0] <= PERM_ROM[8'(s2_aa_ff + s2_z_ff)];
         s3_h_ff[1] <= PERM_ROM[8'(s2_ba_ff + s2_z_ff)];
         s3_h_ff[2] <= PERM_ROM[8'(s2_ab_ff + s2_z_ff)];
         s3_h_ff[3] <= PERM_ROM[8'(s2_bb_ff + s2_z_ff)];
         s3_h_ff[4] <= PERM_ROM[8'(s2_aa_ff + s2_z_ff + 8'd1)];
         s3_h_ff[5] <= PERM_ROM[8'(s2_ba_ff + s2_z_ff + 8'd1)];
         s3_h_ff[6] <= PERM_ROM[8'(s2_ab_ff + s2_z_ff + 8'd1)];
         s3_h_ff[7] <= PERM_ROM[8'(s2_bb_ff + s2_z_ff + 8'd1)];
      end
   end

   // fade: stage 2 inputs, stages 3,4,5
   val_type ft [3];
   assign ft[0] = x_ff[2];
   assign ft[1] = y_ff[2];
   assign ft[2] = z_ff[2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f2_in[i] = qmul(ft[i], val_type'(6) * ft[i] - val_type'(15) * ONE)
                    + val_type'(10) * ONE;
      end
   end

   val_type sq_ff [3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         f2_ff[i]    <= f2_in[i];
         sq_ff[i]    <= qmul(ft[i], ft[i]);
         f3_ff[i][0] <= qmul(x_ff[3 + 0] & '0 | (i == 0 ? x_ff[3] : i == 1 ? y_ff[3] : z_ff[3]),
                             f2_ff[i]);
         f3_ff[i][1] <= qmul(sq_ff[i], i == 0 ? x_ff[3] : i == 1 ? y_ff[3] : z_ff[3]);
         fade_ff[i]  <= qmul(f3_ff[i][1], f3_ff[i][0]);
      end
   end

   // stage 4: gradients (fractions at x_ff[3])
   val_type gx [2], gy [2], gz [2];
   always_comb begin
      gx[0] = x_ff[3];
      gx[1] = x_ff[3] - ONE;
      gy[0] = (dim_p_ff[3] == DIM_1D) ? '0 : y_ff[3];
      gy[1] = (dim_p_ff[3] == DIM_1D) ? '0 : y_ff[3] - ONE;
      gz[0] = (dim_p_ff[3] == DIM_1D || dim_p_ff[3] == DIM_2D) ? '0 : z_ff[3];
      gz[1] = (dim_p_ff[3] == DIM_1D || dim_p_ff[3] == DIM_2D) ? '0 : z_ff[3] - ONE;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         g4_ff[i] <= grad(s3_h_ff[i], gx[i%2], gy[(i/2)%2], gz[i/4]);
      end
   end

   // stage 5: hold gradients until the fade weights arrive
   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         g5_ff[i] <= g4_ff[i];
      end
   end

   // stage 6: x blends (fade ready at stage 6 input)
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         l5_ff[i] <= lerp(g5_ff[2*i], g5_ff[2*i+1], fade_ff[0]);
      end
   end

   val_type fv_ff, fw_ff, fw2_ff;
   always_ff @(posedge clock) begin
      fv_ff  <= fade_ff[1];
      fw_ff  <= fade_ff[2];
      fw2_ff <= fw_ff;
   end

   // stage 7: y blends; stage 8: z blend
   always_ff @(posedge clock) begin
      l6_ff[0] <= (dim_p_ff[6] == DIM_1D) ? l5_ff[0] : lerp(l5_ff[0], l5_ff[1], fv_ff);
      l6_ff[1] <= lerp(l5_ff[2], l5_ff[3], fv_ff);
      n7_ff    <= (dim_p_ff[7] == DIM_1D || dim_p_ff[7] == DIM_2D) ? l6_ff[0]
                  : lerp(l6_ff[0], l6_ff[1], fw2_ff);
   end

   // stage 9: map and saturate
   val_type              mval;
   logic [VAL_W-1:0]     rnd;
   always_comb begin
      mval = ONE + n7_ff;
      rnd  = (VAL_W'(mval) + VAL_W'(1)) >> 1;
   end

   always_ff @(posedge clock) begin
      if (mval[VAL_W-1] || mval == '0) begin
         rsp_noise_value <= '0;
      end else if (rnd > VAL_W'(1 << 16)) begin
         rsp_noise_value <= OUT_W'(1 << 16);
      end else begin
         rsp_noise_value <= rnd[OUT_W-1:0];
      end
   end

   assign rsp_valid = vld_ff[NS-1];

endmodule
